>>> rtl/gbep_pkg.sv
// shared types, constants and modular add for the grid boundary exit path counter
package gbep_pkg;

  // width of one walk count and of the exit total
  localparam int DATA_W = 30;

  // counts are kept modulo this prime
  localparam logic [DATA_W-1:0] MODULUS = 30'd1000000007;

  // default grid and budget limits
  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_MAX_COLS  = 64;
  localparam int DEF_MAX_MOVES = 64;

  // compare width wide enough for request fields and every legal limit
  localparam int CMP_W = 12;

  typedef logic [DATA_W-1:0] count_t;

  // per-cycle sweep flags from the sequencer to the datapath
  typedef struct packed {
    logic valid;    // a cell column is issued this cycle
    logic a_ok;     // issued column lies inside the grid
    logic b_ok;     // row below lies inside the grid
    logic up_ok;    // row above lies inside the grid
    logic left_ok;  // cell being finished has a left neighbor
    logic first;    // first move, counts come from the start cell
    logic hit_a;    // issued cell is the start cell
    logic hit_b;    // cell below the issued one is the start cell
    logic rsel;     // buffer that holds the current counts
  } issue_t;

  // a + b modulo MODULUS, both inputs already reduced
  function automatic count_t add_mod(count_t a, count_t b);
    logic [DATA_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, MODULUS}) begin
      sum = sum - {1'b0, MODULUS};
    end
    return sum[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/grid_boundary_exit_path_counter_unit.sv
// Grid boundary exit path counter: takes one request word (grid size, move budget,
// start cell) and returns the number of four-direction walks of at most the budget
// that leave the grid, modulo 1000000007, plus a flag when the start cell lies off
// the grid. Counts live in two ping-pong memories; each move streams every cell in
// raster order through one read port for the cell row and one for the row below,
// with a row line buffer for the row above. A rejected request or a zero budget
// skips the sweep. No clearing pass is needed: the first move takes its counts
// from the start cell and every later move rewrites each grid cell before it is
// read. The next request is accepted as soon as a result sits in the output
// register.
module grid_boundary_exit_path_counter_unit #(
  parameter int MAX_ROWS  = gbep_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = gbep_pkg::DEF_MAX_COLS,
  parameter int MAX_MOVES = gbep_pkg::DEF_MAX_MOVES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [6:0]  grid_rows_i,
  input  logic [6:0]  grid_cols_i,
  input  logic [6:0]  move_budget_i,
  input  logic [5:0]  origin_row_i,
  input  logic [5:0]  origin_col_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] walk_total_o,
  output logic        bad_request_o
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW = $clog2(MAX_COLS + 1);
  localparam int AW = RW + CW;

  gbep_pkg::issue_t issue;
  logic [RW-1:0]    row;
  logic [SW-1:0]    col;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic [CW-1:0]    lbuf_raddr;
  logic             acc_clr;
  gbep_pkg::count_t acc;

  gbep_pkg::count_t even_a, even_b, odd_a, odd_b;
  gbep_pkg::count_t lbuf_rd;
  logic             lbuf_we;
  logic [CW-1:0]    lbuf_waddr;
  gbep_pkg::count_t lbuf_wdata;
  logic             even_we, odd_we;
  logic [AW-1:0]    ram_waddr;
  gbep_pkg::count_t ram_wdata;

  // request intake, sweep counters and result register
  gbep_seq #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_MOVES (MAX_MOVES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .grid_rows_i   (grid_rows_i),
    .grid_cols_i   (grid_cols_i),
    .move_budget_i (move_budget_i),
    .origin_row_i  (origin_row_i),
    .origin_col_i  (origin_col_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .walk_total_o  (walk_total_o),
    .bad_request_o (bad_request_o),
    .acc_i         (acc),
    .acc_clr_o     (acc_clr),
    .issue_o       (issue),
    .row_o         (row),
    .col_o         (col),
    .raddr_a_o     (raddr_a),
    .raddr_b_o     (raddr_b),
    .lbuf_raddr_o  (lbuf_raddr)
  );

  // count buffer for even moves
  gbep_ram #(
    .ADDR_W (AW)
  ) u_ram_even (
    .clk_i     (clk_i),
    .we_i      (even_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (even_a),
    .rdata_b_o (even_b)
  );

  // count buffer for odd moves
  gbep_ram #(
    .ADDR_W (AW)
  ) u_ram_odd (
    .clk_i     (clk_i),
    .we_i      (odd_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (odd_a),
    .rdata_b_o (odd_b)
  );

  // previous row of counts
  gbep_lbuf #(
    .ADDR_W (CW)
  ) u_lbuf (
    .clk_i   (clk_i),
    .we_i    (lbuf_we),
    .waddr_i (lbuf_waddr),
    .wdata_i (lbuf_wdata),
    .raddr_i (lbuf_raddr),
    .rdata_o (lbuf_rd)
  );

  // neighbor gather, exit terms and total
  gbep_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .row_i        (row),
    .col_i        (col),
    .acc_clr_i    (acc_clr),
    .even_a_i     (even_a),
    .even_b_i     (even_b),
    .odd_a_i      (odd_a),
    .odd_b_i      (odd_b),
    .lbuf_rd_i    (lbuf_rd),
    .lbuf_we_o    (lbuf_we),
    .lbuf_waddr_o (lbuf_waddr),
    .lbuf_wdata_o (lbuf_wdata),
    .even_we_o    (even_we),
    .odd_we_o     (odd_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .acc_o        (acc)
  );

endmodule

>>> rtl/gbep_ram.sv
// count buffer: one write port, two registered read ports
module gbep_ram #(
  parameter int ADDR_W = 12
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ADDR_W-1:0]      waddr_i,
  input  gbep_pkg::count_t       wdata_i,
  input  logic [ADDR_W-1:0]      raddr_a_i,
  input  logic [ADDR_W-1:0]      raddr_b_i,
  output gbep_pkg::count_t       rdata_a_o,
  output gbep_pkg::count_t       rdata_b_o
);

  gbep_pkg::count_t mem_q [2**ADDR_W];
  gbep_pkg::count_t rdata_a_q;
  gbep_pkg::count_t rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports, registered
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> rtl/gbep_lbuf.sv
// row line buffer: holds the previous row of counts for the up neighbor
module gbep_lbuf #(
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  gbep_pkg::count_t  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output gbep_pkg::count_t  rdata_o
);

  gbep_pkg::count_t mem_q [2**ADDR_W];
  gbep_pkg::count_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gbep_dp.sv
// cell datapath: neighbor gather, exit term and total accumulation
module gbep_dp #(
  parameter int MAX_ROWS = gbep_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gbep_pkg::DEF_MAX_COLS,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int SW = $clog2(MAX_COLS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gbep_pkg::issue_t      issue_i,
  input  logic [RW-1:0]         row_i,
  input  logic [SW-1:0]         col_i,
  input  logic                  acc_clr_i,
  input  gbep_pkg::count_t      even_a_i,
  input  gbep_pkg::count_t      even_b_i,
  input  gbep_pkg::count_t      odd_a_i,
  input  gbep_pkg::count_t      odd_b_i,
  input  gbep_pkg::count_t      lbuf_rd_i,
  output logic                  lbuf_we_o,
  output logic [CW-1:0]         lbuf_waddr_o,
  output gbep_pkg::count_t      lbuf_wdata_o,
  output logic                  even_we_o,
  output logic                  odd_we_o,
  output logic [RW+CW-1:0]      ram_waddr_o,
  output gbep_pkg::count_t      ram_wdata_o,
  output gbep_pkg::count_t      acc_o
);

  localparam int AW = RW + CW;

  // read stage registers
  gbep_pkg::issue_t iss_q;
  logic [RW-1:0]    row_q;
  logic [SW-1:0]    col_q;

  // column shift taps
  gbep_pkg::count_t prv_c_q;
  gbep_pkg::count_t prv2_c_q;
  gbep_pkg::count_t prv_d_q;
  gbep_pkg::count_t prv_u_q;

  // gather stage
  gbep_pkg::count_t rd_a;
  gbep_pkg::count_t rd_b;
  gbep_pkg::count_t center_now;
  gbep_pkg::count_t down_now;
  gbep_pkg::count_t up_now;
  gbep_pkg::count_t left_v;
  gbep_pkg::count_t v2;
  gbep_pkg::count_t ta_d;
  gbep_pkg::count_t tb_d;
  logic [2:0]       sides;
  logic             cell_vld;

  logic             st2_vld_q;
  logic             st2_rsel_q;
  logic [AW-1:0]    st2_addr_q;
  gbep_pkg::count_t s1_q;
  gbep_pkg::count_t s2_q;
  gbep_pkg::count_t ta_q;
  gbep_pkg::count_t tb_q;

  logic             ex_vld_q;
  gbep_pkg::count_t ex_q;
  gbep_pkg::count_t acc_q;

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= '0;
    end else begin
      iss_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_i;
    col_q <= col_i;
  end

  // pick the current buffer and mask reads outside the grid
  always_comb begin
    rd_a = iss_q.rsel ? odd_a_i : even_a_i;
    rd_b = iss_q.rsel ? odd_b_i : even_b_i;
    if (!iss_q.a_ok) begin
      center_now = '0;
    end else if (iss_q.first) begin
      center_now = gbep_pkg::count_t'(iss_q.hit_a);
    end else begin
      center_now = rd_a;
    end
    if (!iss_q.b_ok) begin
      down_now = '0;
    end else if (iss_q.first) begin
      down_now = gbep_pkg::count_t'(iss_q.hit_b);
    end else begin
      down_now = rd_b;
    end
    up_now = iss_q.up_ok ? lbuf_rd_i : '0;
  end

  // shift taps advance once per issued column
  always_ff @(posedge clk_i) begin
    if (iss_q.valid) begin
      prv2_c_q <= prv_c_q;
      prv_c_q  <= center_now;
      prv_d_q  <= down_now;
      prv_u_q  <= up_now;
    end
  end

  // line buffer keeps this row's counts for the next row
  assign lbuf_we_o    = iss_q.valid && iss_q.a_ok;
  assign lbuf_waddr_o = col_q[CW-1:0];
  assign lbuf_wdata_o = center_now;

  // exit term for the finished cell, split into two addends
  always_comb begin
    cell_vld = iss_q.valid && (col_q != '0);
    left_v   = iss_q.left_ok ? prv2_c_q : '0;
    sides    = 3'(!iss_q.up_ok) + 3'(!iss_q.b_ok) + 3'(!iss_q.left_ok) + 3'(!iss_q.a_ok);
    v2       = gbep_pkg::add_mod(prv_c_q, prv_c_q);
    if (sides >= 3'd2) begin
      ta_d = v2;
    end else if (sides == 3'd1) begin
      ta_d = prv_c_q;
    end else begin
      ta_d = '0;
    end
    if (sides == 3'd4) begin
      tb_d = v2;
    end else if (sides == 3'd3) begin
      tb_d = prv_c_q;
    end else begin
      tb_d = '0;
    end
  end

  // gather stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st2_vld_q <= 1'b0;
    end else begin
      st2_vld_q <= cell_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    st2_rsel_q <= iss_q.rsel;
    st2_addr_q <= {row_q, CW'(col_q - SW'(1))};
    s1_q       <= gbep_pkg::add_mod(prv_u_q, prv_d_q);
    s2_q       <= gbep_pkg::add_mod(left_v, center_now);
    ta_q       <= ta_d;
    tb_q       <= tb_d;
  end

  // write the new count into the other buffer
  assign ram_wdata_o = gbep_pkg::add_mod(s1_q, s2_q);
  assign ram_waddr_o = st2_addr_q;
  assign even_we_o   = st2_vld_q && st2_rsel_q;
  assign odd_we_o    = st2_vld_q && !st2_rsel_q;

  // exit term stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q <= 1'b0;
    end else begin
      ex_vld_q <= st2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ex_q <= gbep_pkg::add_mod(ta_q, tb_q);
  end

  // running exit total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (acc_clr_i) begin
      acc_q <= '0;
    end else if (ex_vld_q) begin
      acc_q <= gbep_pkg::add_mod(acc_q, ex_q);
    end
  end

  assign acc_o = acc_q;

endmodule

>>> rtl/gbep_seq.sv
// sweep sequencer: request intake, cell and move counters, result register
module gbep_seq #(
  parameter int MAX_ROWS  = gbep_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = gbep_pkg::DEF_MAX_COLS,
  parameter int MAX_MOVES = gbep_pkg::DEF_MAX_MOVES,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int SW = $clog2(MAX_COLS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [6:0]         grid_rows_i,
  input  logic [6:0]         grid_cols_i,
  input  logic [6:0]         move_budget_i,
  input  logic [5:0]         origin_row_i,
  input  logic [5:0]         origin_col_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [29:0]        walk_total_o,
  output logic               bad_request_o,
  input  gbep_pkg::count_t   acc_i,
  output logic               acc_clr_o,
  output gbep_pkg::issue_t   issue_o,
  output logic [RW-1:0]      row_o,
  output logic [SW-1:0]      col_o,
  output logic [RW+CW-1:0]   raddr_a_o,
  output logic [RW+CW-1:0]   raddr_b_o,
  output logic [CW-1:0]      lbuf_raddr_o
);

  localparam int NW  = $clog2(MAX_ROWS + 1);
  localparam int MW  = $clog2(MAX_MOVES + 1);
  localparam int CMP = gbep_pkg::CMP_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // last drain step, after which the last exit term has landed
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [NW-1:0] rows_q, rows_d;
  logic [SW-1:0] cols_q, cols_d;
  logic [MW-1:0] moves_q, moves_d;
  logic [RW-1:0] or_q, or_d;
  logic [CW-1:0] oc_q, oc_d;
  logic          bad_q, bad_d;
  logic [RW-1:0] r_q, r_d;
  logic [SW-1:0] s_q, s_d;
  logic [MW-1:0] m_q, m_d;
  logic          sel_q, sel_d;
  logic [1:0]    drain_q, drain_d;
  logic          out_vld_q, out_vld_d;
  logic [29:0]   total_q, total_d;
  logic          obad_q, obad_d;

  logic [CMP-1:0] rows_c;
  logic [CMP-1:0] cols_c;
  logic [CMP-1:0] moves_c;
  logic           req_bad;
  logic           accept;
  logic [NW-1:0]  r_next;
  logic           row_end;

  // saturate the request and check the grid size and start cell
  always_comb begin
    rows_c  = (CMP'(grid_rows_i) > CMP'(MAX_ROWS)) ? CMP'(MAX_ROWS) : CMP'(grid_rows_i);
    cols_c  = (CMP'(grid_cols_i) > CMP'(MAX_COLS)) ? CMP'(MAX_COLS) : CMP'(grid_cols_i);
    moves_c = (CMP'(move_budget_i) > CMP'(MAX_MOVES)) ? CMP'(MAX_MOVES)
                                                      : CMP'(move_budget_i);
    req_bad = (rows_c == '0) || (cols_c == '0) ||
              (CMP'(origin_row_i) >= rows_c) || (CMP'(origin_col_i) >= cols_c);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign acc_clr_o  = accept;
  assign r_next     = NW'(r_q) + NW'(1);
  assign row_end    = (s_q == cols_q);

  // sweep addresses and flags for the cell column issued this cycle
  always_comb begin
    issue_o.valid   = (state_q == ST_RUN);
    issue_o.a_ok    = (s_q < cols_q);
    issue_o.b_ok    = (r_next < rows_q);
    issue_o.up_ok   = (r_q != '0);
    issue_o.left_ok = (s_q > SW'(1));
    issue_o.first   = (m_q == '0);
    issue_o.hit_a   = (r_q == or_q) && (s_q == SW'(oc_q));
    issue_o.hit_b   = (r_next == NW'(or_q)) && (s_q == SW'(oc_q));
    issue_o.rsel    = sel_q;
    row_o           = r_q;
    col_o           = s_q;
    raddr_a_o       = {r_q, s_q[CW-1:0]};
    raddr_b_o       = {r_next[RW-1:0], s_q[CW-1:0]};
    lbuf_raddr_o    = s_q[CW-1:0];
  end

  // control state machine
  always_comb begin
    state_d   = state_q;
    rows_d    = rows_q;
    cols_d    = cols_q;
    moves_d   = moves_q;
    or_d      = or_q;
    oc_d      = oc_q;
    bad_d     = bad_q;
    r_d       = r_q;
    s_d       = s_q;
    m_d       = m_q;
    sel_d     = sel_q;
    drain_d   = drain_q;
    out_vld_d = out_vld_q && !out_ready_i;
    total_d   = total_q;
    obad_d    = obad_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rows_d  = NW'(rows_c);
          cols_d  = SW'(cols_c);
          moves_d = MW'(moves_c);
          or_d    = RW'(origin_row_i);
          oc_d    = CW'(origin_col_i);
          bad_d   = req_bad;
          r_d     = '0;
          s_d     = '0;
          m_d     = '0;
          sel_d   = 1'b0;
          if (req_bad || (moves_c == '0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (row_end) begin
          s_d = '0;
          if (r_next == rows_q) begin
            drain_d = '0;
            state_d = ST_DRAIN;
          end else begin
            r_d = r_next[RW-1:0];
          end
        end else begin
          s_d = s_q + SW'(1);
        end
      end
      ST_DRAIN: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == DRAIN_LAST) begin
          sel_d = !sel_q;
          m_d   = m_q + MW'(1);
          r_d   = '0;
          s_d   = '0;
          if (m_q + MW'(1) == moves_q) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          total_d   = bad_q ? '0 : acc_i;
          obad_d    = bad_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      r_q       <= '0;
      s_q       <= '0;
      m_q       <= '0;
      sel_q     <= 1'b0;
      drain_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      r_q       <= r_d;
      s_q       <= s_d;
      m_q       <= m_d;
      sel_q     <= sel_d;
      drain_q   <= drain_d;
      out_vld_q <= out_vld_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    rows_q  <= rows_d;
    cols_q  <= cols_d;
    moves_q <= moves_d;
    or_q    <= or_d;
    oc_q    <= oc_d;
    bad_q   <= bad_d;
    total_q <= total_d;
    obad_q  <= obad_d;
  end

  assign out_valid_o   = out_vld_q;
  assign walk_total_o  = total_q;
  assign bad_request_o = obad_q;

`ifndef SYNTH
  // an accepted word always starts work
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted word did not leave idle");

  // the column counter never runs past the extra flush column
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (s_q <= cols_q))
    else $error("column counter beyond grid width");

  // buffers swap only at the end of a move or at request start
  a_swap_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q != $past(sel_q)) |-> ($past(state_q) == ST_DRAIN || $past(state_q) == ST_IDLE))
    else $error("buffer swap outside a move boundary");

  // a rejected start cell never collects exits
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && bad_q) |-> (acc_i == '0))
    else $error("exit total nonzero for a rejected request");
`endif

endmodule

>>> bench/tb_top.sv
// self-checking bench for the grid boundary exit path counter: directed and random requests
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      GRID_MAX  = 64;
  localparam int      MOVES_MAX = 64;
  localparam longint  PRIME     = 64'd1000000007;
  localparam int      IDLE_MAX  = 17;
  localparam int      TAIL_WAIT = 64;

  typedef logic [29:0] walk_cnt_t;

  typedef struct {
    logic [6:0] rows;
    logic [6:0] cols;
    logic [6:0] moves;
    logic [5:0] orow;
    logic [5:0] ocol;
    bit         hold_for_results;  // wait until every outstanding answer is back
    bit         calm;              // final stretch, no idling on either side
  } exit_req_t;

  typedef struct {
    walk_cnt_t walk_total;
    logic      bad_request;
  } exit_ans_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [6:0]  grid_rows = '0;
  logic [6:0]  grid_cols = '0;
  logic [6:0]  move_budget = '0;
  logic [5:0]  origin_row = '0;
  logic [5:0]  origin_col = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [29:0] walk_total_o;
  logic        bad_request_o;

  exit_req_t   pending_requests[$];
  exit_ans_t   expected_exits[$];
  walk_cnt_t   walk_now[GRID_MAX][GRID_MAX];
  walk_cnt_t   walk_next[GRID_MAX][GRID_MAX];
  int          error_count = 0;
  int          results_seen = 0;
  int          bad_seen = 0;
  int          words_sent = 0;
  bit          calm_phase = 1'b0;
  longint      cycle_count = 0;
  longint      cycle_limit = 0;
  longint      slow_budget = 0;

  grid_boundary_exit_path_counter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .grid_rows_i   (grid_rows),
    .grid_cols_i   (grid_cols),
    .move_budget_i (move_budget),
    .origin_row_i  (origin_row),
    .origin_col_i  (origin_col),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .walk_total_o  (walk_total_o),
    .bad_request_o (bad_request_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sum of two reduced counts, reduced again
  function automatic walk_cnt_t mod_sum(walk_cnt_t a, walk_cnt_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s >= PRIME) begin
      s = s - PRIME;
    end
    return walk_cnt_t'(s);
  endfunction

  // ping-pong sweep over the grid, one pass per move
  function automatic exit_ans_t predict_exit_walks(exit_req_t rq);
    int        rows;
    int        cols;
    int        moves;
    int        sides;
    walk_cnt_t v;
    exit_ans_t ans;
    rows  = (rq.rows > GRID_MAX) ? GRID_MAX : int'(rq.rows);
    cols  = (rq.cols > GRID_MAX) ? GRID_MAX : int'(rq.cols);
    moves = (rq.moves > MOVES_MAX) ? MOVES_MAX : int'(rq.moves);
    ans.walk_total  = '0;
    ans.bad_request = 1'b0;
    if (rows == 0 || cols == 0 || int'(rq.orow) >= rows || int'(rq.ocol) >= cols) begin
      ans.bad_request = 1'b1;
      return ans;
    end
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        walk_now[r][c] = '0;
      end
    end
    walk_now[rq.orow][rq.ocol] = 30'd1;
    for (int s = 0; s < moves; s++) begin
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          walk_next[r][c] = '0;
        end
      end
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          v = walk_now[r][c];
          if (v != '0) begin
            sides = int'(r == 0) + int'(r == rows - 1) + int'(c == 0) + int'(c == cols - 1);
            ans.walk_total = mod_sum(ans.walk_total,
                                     walk_cnt_t'((longint'(v) * sides) % PRIME));
            if (r + 1 < rows) walk_next[r+1][c] = mod_sum(walk_next[r+1][c], v);
            if (r > 0)        walk_next[r-1][c] = mod_sum(walk_next[r-1][c], v);
            if (c + 1 < cols) walk_next[r][c+1] = mod_sum(walk_next[r][c+1], v);
            if (c > 0)        walk_next[r][c-1] = mod_sum(walk_next[r][c-1], v);
          end
        end
      end
      walk_now = walk_next;
    end
    return ans;
  endfunction

  // queue one request and add its worst-case cycle cost to the budget
  function automatic void push_request(int rows, int cols, int moves, int orow, int ocol,
                                       bit hold = 1'b0, bit calm = 1'b0);
    exit_req_t rq;
    longint    r;
    longint    c;
    longint    m;
    rq.rows  = 7'(rows);
    rq.cols  = 7'(cols);
    rq.moves = 7'(moves);
    rq.orow  = 6'(orow);
    rq.ocol  = 6'(ocol);
    rq.hold_for_results = hold;
    rq.calm  = calm;
    pending_requests.push_back(rq);
    r = (rq.rows > GRID_MAX) ? GRID_MAX : rq.rows;
    c = (rq.cols > GRID_MAX) ? GRID_MAX : rq.cols;
    m = (rq.moves > MOVES_MAX) ? MOVES_MAX : rq.moves;
    slow_budget += m * r * (c + 1) + 3 * m + 4 + 2 * IDLE_MAX + 20;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    exit_req_t rq;
    bit        busy;
    int        idle_left;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready_o) begin
        expected_exits.push_back(predict_exit_walks('{grid_rows, grid_cols, move_budget,
                                                      origin_row, origin_col, 1'b0, 1'b0}));
        words_sent++;
        busy = 1'b0;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
          idle_left = $urandom_range(1, IDLE_MAX);
        end
      end
      if (!busy) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].hold_for_results && expected_exits.size() > 0)) begin
          rq = pending_requests.pop_front();
          grid_rows   <= rq.rows;
          grid_cols   <= rq.cols;
          move_budget <= rq.moves;
          origin_row  <= rq.orow;
          origin_col  <= rq.ocol;
          if (rq.calm) calm_phase = 1'b1;
          busy = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    exit_ans_t want;
    int        stall_left;
    bit        rdy;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (bad_request_o) bad_seen++;
        if (expected_exits.size() == 0) begin
          $error("result word with nothing pending: walk_total=%0d bad_request=%0b",
                 walk_total_o, bad_request_o);
          error_count++;
        end else begin
          want = expected_exits.pop_front();
          if (walk_total_o !== want.walk_total) begin
            $error("walk_total expected %0d actual %0d", want.walk_total, walk_total_o);
            error_count++;
          end
          if (bad_request_o !== want.bad_request) begin
            $error("bad_request expected %0b actual %0b", want.bad_request, bad_request_o);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, IDLE_MAX) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_limit > 0 && cycle_count > cycle_limit) begin
      $error("timeout after %0d cycles, %0d answers outstanding",
             cycle_count, expected_exits.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int kind;
    int n;
    // directed: extremes, saturation, empty grids, off-grid starts, zero budget
    push_request(1, 1, 0, 0, 0);
    push_request(1, 1, 1, 0, 0);
    push_request(1, 1, 64, 0, 0);
    push_request(2, 2, 2, 0, 0);
    push_request(64, 64, 64, 0, 0);
    push_request(127, 127, 1, 63, 63);
    push_request(127, 3, 127, 63, 2);
    push_request(3, 127, 100, 1, 63);
    push_request(64, 64, 5, 63, 63);
    push_request(127, 127, 2, 63, 0);
    push_request(0, 5, 3, 0, 0);
    push_request(5, 0, 3, 0, 0);
    push_request(0, 0, 0, 0, 0);
    push_request(4, 4, 3, 4, 0);
    push_request(4, 4, 3, 0, 4);
    push_request(1, 1, 0, 63, 63);
    push_request(64, 2, 0, 63, 1);
    push_request(127, 127, 0, 0, 0);
    push_request(3, 3, 0, 1, 1);
    push_request(8, 1, 20, 3, 0);
    push_request(1, 8, 20, 0, 7);
    push_request(10, 10, 64, 5, 5);
    // random: mostly small well-formed requests, some tall or wide grids, some noise
    for (int i = 0; i < 100; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        n = $urandom_range(1, 10);
        push_request(n, $urandom_range(1, 10), $urandom_range(0, 14), 0, 0,
                     i == 0 || i == 50, i >= 85);
        pending_requests[$].orow = 6'($urandom_range(0, n - 1));
        pending_requests[$].ocol = 6'($urandom_range(0, pending_requests[$].cols - 1));
      end else if (kind == 8) begin
        if ($urandom_range(0, 1) == 0) begin
          push_request($urandom_range(0, 127), $urandom_range(1, 3), $urandom_range(0, 10),
                       $urandom_range(0, 63), $urandom_range(0, 3), 1'b0, i >= 85);
        end else begin
          push_request($urandom_range(1, 3), $urandom_range(0, 127), $urandom_range(0, 10),
                       $urandom_range(0, 3), $urandom_range(0, 63), 1'b0, i >= 85);
        end
      end else begin
        push_request($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 3),
                     $urandom_range(0, 63), $urandom_range(0, 63), 1'b0, i >= 85);
      end
    end
    cycle_limit = 3 * slow_budget + 5000;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid || expected_exits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (expected_exits.size() != 0) begin
      $error("%0d answers never arrived", expected_exits.size());
      error_count++;
    end

    $display("sent %0d requests and checked %0d answers, %0d of them rejected starts",
             words_sent, results_seen, bad_seen);
    $display("grids from 1x1 up to saturated 64x64, budgets up to 64 moves, %0d cycles",
             cycle_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> grid_boundary_exit_path_counter_unit.f
rtl/gbep_pkg.sv
rtl/gbep_ram.sv
rtl/gbep_lbuf.sv
rtl/gbep_dp.sv
rtl/gbep_seq.sv
rtl/grid_boundary_exit_path_counter_unit.sv
bench/tb_top.sv
